// ===== hdl/fvnh_pkg.sv =====
package fvnh_pkg;

    // Sequencer states of the height engine
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_OCT,
        ST_TRD,
        ST_BLEND,
        ST_HASH,
        ST_SMOOTH,
        ST_MIX,
        ST_WEIGHT,
        ST_DONE
    } fvnh_state_t;

    // Request kinds carried in tuser
    localparam logic FUNC_HEIGHT = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_OCTAVES   = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [1:0] REG_PERSIST   = 2'd2;
    localparam logic [1:0] REG_FIRST_SET = 2'd3;

    localparam int OCT_W  = 5;   // octave counters, up to sixteen octaves
    localparam int LAT_W  = 32;  // lattice value, Q1.30
    localparam int SM_W   = 36;  // smoothed value, 34 fraction bits
    localparam int MUL_W  = 33;  // shared multiplier operand
    localparam int PROD_W = 66;  // shared multiplier product
    localparam int ACC_W  = 64;  // octave sum
    localparam int MIX_W  = 56;  // blend accumulator

    // Raised-cosine blend weights, Q1.16, at k/32
    function automatic logic [16:0] blend_entry(input logic [5:0] k);
        logic [16:0] v;
        case (k)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd158;
            6'd2:  v = 17'd630;
            6'd3:  v = 17'd1411;
            6'd4:  v = 17'd2494;
            6'd5:  v = 17'd3869;
            6'd6:  v = 17'd5522;
            6'd7:  v = 17'd7438;
            6'd8:  v = 17'd9598;
            6'd9:  v = 17'd11980;
            6'd10: v = 17'd14563;
            6'd11: v = 17'd17321;
            6'd12: v = 17'd20228;
            6'd13: v = 17'd23256;
            6'd14: v = 17'd26375;
            6'd15: v = 17'd29556;
            6'd16: v = 17'd32768;
            6'd17: v = 17'd35980;
            6'd18: v = 17'd39161;
            6'd19: v = 17'd42280;
            6'd20: v = 17'd45308;
            6'd21: v = 17'd48215;
            6'd22: v = 17'd50973;
            6'd23: v = 17'd53556;
            6'd24: v = 17'd55938;
            6'd25: v = 17'd58098;
            6'd26: v = 17'd60014;
            6'd27: v = 17'd61667;
            6'd28: v = 17'd63042;
            6'd29: v = 17'd64125;
            6'd30: v = 17'd64906;
            6'd31: v = 17'd65378;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/fractal_value_noise_height.sv =====
// Channel   Direction  Signals                         Moves
// s_*       in         s_tvalid s_tready s_tdata s_tuser  height or table-load request
// m_*       out        m_tvalid m_tready m_tdata          one height per height request
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register write, always ready
//
// A height request works through the octaves one after another, between set-up and
// hand-off; the blend, the lattice hash, the mix and the weighting take turns on
// the one shared multiplier.
// A table-load request gives no result and leaves the input ready.
// rst_n sets control and configuration to their defaults at once; the hash table is not cleared.
// The result waits in an output register; a stalled output only holds the next
// height in its last cycle, and s_tready stays low while a height is worked out.
module fractal_value_noise_height #(
    parameter int TABLE_SETS  = 16,
    parameter int MAX_OCTAVES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: x_coord[15:0], z_coord[31:16], table_addr[37:32], table_word[68:38]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // s_tuser: func[0]
    input  logic [0:0]  s_tuser,
    // m_tdata: height[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import fvnh_pkg::*;

    localparam int DEPTH  = TABLE_SETS * 3;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SETR_W = $clog2(TABLE_SETS + 16);
    localparam int BASE_W = SETR_W + 2;

    fvnh_state_t state_reg, state_next;

    // configuration
    logic [3:0]  oct_cfg_reg;
    logic [15:0] amp_reg;
    logic [15:0] pers_reg;
    logic [3:0]  fset_reg;

    // sequencer counters
    logic [2:0]        step_reg;
    logic [3:0]        j_reg;
    logic [1:0]        q_reg, cx_reg, cz_reg, mi_reg;
    logic [OCT_W-1:0]  oi_reg, noct_reg;

    // datapath
    logic signed [15:0]       x_reg, z_reg;
    logic [SETR_W-1:0]        set_reg;
    logic [30:0]              h0_reg, h1_reg, h2_reg;
    logic signed [17:0]       xi_reg, zi_reg;
    logic [15:0]              fx_reg, fz_reg;
    logic [16:0]              wx_reg, wz_reg;
    logic [31:0]              n_reg;
    logic signed [LAT_W-1:0]  lat_reg [16];
    logic signed [SM_W-1:0]   sm_reg, v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [MIX_W-1:0]  mix_reg;
    logic [16:0]              p_reg;
    logic [24:0]              wt_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MUL_W-1:0]  ma_reg, mb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     out_valid_reg;
    logic [31:0]              out_data_reg;

    logic s_acc;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // ---------------------------------------------------------------
    // Hash table: loads write straight from the request, octave start
    // reads the three words of the current set.
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_rd_addr;
    logic [30:0]   ram_rd_data;
    logic [BASE_W-1:0] base_full;
    logic [1:0]    rd_off;

    assign ram_we = s_acc && (s_tuser[0] == FUNC_LOAD)
                    && (32'(s_tdata[37:32]) < 32'(DEPTH));
    assign base_full = (BASE_W'(set_reg) << 1) + BASE_W'(set_reg);
    assign rd_off = (step_reg > 3'd2) ? 2'd2 : step_reg[1:0];
    assign ram_rd_addr = AW'(base_full + BASE_W'(rd_off));

    fvnh_ram #(
        .WIDTH (31),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(s_tdata[37:32])),
        .wr_data (s_tdata[68:38]),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------
    // Coordinate split: truncate toward zero, keep the fraction magnitude
    // ---------------------------------------------------------------
    function automatic logic [16:0] mag_of(input logic signed [15:0] c);
        logic [16:0] ce;
        ce = {c[15], c};
        return c[15] ? (17'd0 - ce) : ce;
    endfunction

    function automatic logic signed [17:0] split_int(input logic signed [15:0] c,
                                                      input logic [3:0] s);
        logic [16:0] q;
        q = mag_of(c) >> s;
        return c[15] ? (18'sd0 - $signed({1'b0, q})) : $signed({1'b0, q});
    endfunction

    function automatic logic [15:0] split_frac(input logic signed [15:0] c,
                                               input logic [3:0] s);
        logic [16:0] m;
        logic [16:0] sh;
        m  = mag_of(c) & ((17'd1 << s) - 17'd1);
        sh = m << (5'd16 - {1'b0, s});
        return (s == 4'd0) ? 16'd0 : sh[15:0];
    endfunction

    logic [OCT_W-1:0] s_full;
    logic [OCT_W-1:0] oct_in, oct_clamped;
    assign s_full = noct_reg - oi_reg - OCT_W'(1);
    assign oct_in = OCT_W'(oct_cfg_reg);
    always_comb
    begin
        oct_clamped = oct_in;
        if (oct_in == '0)
        begin
            oct_clamped = OCT_W'(1);
        end
        if (32'(oct_in) > MAX_OCTAVES)
        begin
            oct_clamped = OCT_W'(MAX_OCTAVES);
        end
    end

    // Blend weight: table entry plus linear step between neighbours
    logic [16:0] tab_kx, tab_kz, diff_x, diff_z;
    assign tab_kx = blend_entry({1'b0, fx_reg[15:11]});
    assign tab_kz = blend_entry({1'b0, fz_reg[15:11]});
    assign diff_x = blend_entry({1'b0, fx_reg[15:11]} + 6'd1) - tab_kx;
    assign diff_z = blend_entry({1'b0, fz_reg[15:11]} + 6'd1) - tab_kz;

    // Lattice hash seed for grid point j of the 4x4 patch
    logic [31:0] gx, gz, n0, hash_n;
    logic [31:0] t_sum;
    logic signed [LAT_W-1:0] lat_new;
    assign gx = 32'(xi_reg) + {30'd0, j_reg[1:0]} - 32'd1;
    assign gz = 32'(zi_reg) + {30'd0, j_reg[3:2]} - 32'd1;
    assign n0 = gx + (gz << 5) + (gz << 3) + (gz << 1);
    assign hash_n = (n0 << 13) ^ n0;
    assign t_sum = prod_reg[31:0] + {1'b0, h2_reg};
    assign lat_new = $signed(32'h4000_0000 - {1'b0, t_sum[30:0]});

    // Smoothing: one neighbour a cycle, weight by shift
    logic [3:0] nb_sel;
    logic [1:0] sm_sh;
    logic signed [SM_W-1:0] sm_term;
    assign nb_sel = {2'(q_reg[1] + cz_reg), 2'(q_reg[0] + cx_reg)};
    assign sm_sh = 2'(cx_reg == 2'd1) + 2'(cz_reg == 2'd1);
    assign sm_term = SM_W'(lat_reg[nb_sel]) <<< sm_sh;

    // Blend a*(1-w) + b*w = a + (b-a)*w, the difference in two pieces
    logic signed [SM_W-1:0] mix_a, mix_b;
    logic signed [SM_W:0]   mix_d;
    logic [16:0]            mix_w;
    always_comb
    begin
        case (mi_reg)
            2'd0:
            begin
                mix_a = v0_reg;
                mix_b = v1_reg;
            end
            2'd1:
            begin
                mix_a = v2_reg;
                mix_b = v3_reg;
            end
            default:
            begin
                mix_a = v0_reg;
                mix_b = v2_reg;
            end
        endcase
    end
    assign mix_w = (mi_reg == 2'd2) ? wz_reg : wx_reg;
    assign mix_d = (SM_W+1)'(mix_b) - (SM_W+1)'(mix_a);

    logic signed [31:0] oct_r;
    assign oct_r = v0_reg[35:4];

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (s_tuser[0] == FUNC_HEIGHT))
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (set_reg < SETR_W'(TABLE_SETS))
                begin
                    state_next = ST_OCT;
                end
            end
            ST_OCT:
            begin
                state_next = ST_TRD;
            end
            ST_TRD:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if ((step_reg == 3'd7) && (j_reg == 4'd15))
                begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                if ((cx_reg == 2'd2) && (cz_reg == 2'd2) && (q_reg == 2'd3))
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if ((step_reg == 3'd4) && (mi_reg == 2'd2))
                begin
                    state_next = ST_WEIGHT;
                end
            end
            ST_WEIGHT:
            begin
                if (step_reg == 3'd5)
                begin
                    state_next = (OCT_W'(oi_reg + OCT_W'(1)) == noct_reg) ? ST_DONE : ST_OCT;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Control: configuration, counters, output valid
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cfg_reg   <= 4'd4;
            amp_reg       <= 16'd2560;
            pers_reg      <= 16'd32768;
            fset_reg      <= 4'd0;
            step_reg      <= '0;
            j_reg         <= '0;
            q_reg         <= '0;
            cx_reg        <= '0;
            cz_reg        <= '0;
            mi_reg        <= '0;
            oi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_OCTAVES:   oct_cfg_reg <= cfg_data[3:0];
                    REG_AMPLITUDE: amp_reg     <= cfg_data;
                    REG_PERSIST:   pers_reg    <= cfg_data;
                    REG_FIRST_SET: fset_reg    <= cfg_data[3:0];
                    default:       fset_reg    <= fset_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    oi_reg   <= '0;
                end
                ST_OCT:
                begin
                    step_reg <= '0;
                    j_reg    <= '0;
                    q_reg    <= '0;
                    cx_reg   <= '0;
                    cz_reg   <= '0;
                    mi_reg   <= '0;
                end
                ST_TRD, ST_BLEND:
                begin
                    step_reg <= (state_next != state_reg) ? 3'd0 : step_reg + 3'd1;
                end
                ST_HASH:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7)
                    begin
                        j_reg <= j_reg + 4'd1;
                    end
                end
                ST_SMOOTH:
                begin
                    // walk the 3x3 neighbourhood, then advance to the next corner
                    cx_reg <= (cx_reg == 2'd2) ? 2'd0 : cx_reg + 2'd1;
                    if (cx_reg == 2'd2)
                    begin
                        cz_reg <= (cz_reg == 2'd2) ? 2'd0 : cz_reg + 2'd1;
                        if (cz_reg == 2'd2)
                        begin
                            q_reg <= q_reg + 2'd1;
                        end
                    end
                end
                ST_MIX:
                begin
                    step_reg <= (step_reg == 3'd4) ? 3'd0 : step_reg + 3'd1;
                    if (step_reg == 3'd4)
                    begin
                        mi_reg <= mi_reg + 2'd1;
                    end
                end
                ST_WEIGHT:
                begin
                    step_reg <= (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
                    if (step_reg == 3'd5)
                    begin
                        oi_reg <= oi_reg + OCT_W'(1);
                    end
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase

            if ((state_reg == ST_DONE) && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared multiplier, registered product
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= ma_reg * mb_reg;
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    x_reg    <= $signed(s_tdata[15:0]);
                    z_reg    <= $signed(s_tdata[31:16]);
                    noct_reg <= oct_clamped;
                    set_reg  <= SETR_W'(fset_reg);
                    acc_reg  <= '0;
                    p_reg    <= 17'd65536;
                end
            end
            ST_WRAP:
            begin
                // reduce the first set modulo the table size
                if (set_reg >= SETR_W'(TABLE_SETS))
                begin
                    set_reg <= set_reg - SETR_W'(TABLE_SETS);
                end
            end
            ST_OCT:
            begin
                xi_reg <= split_int(x_reg, s_full[3:0]);
                zi_reg <= split_int(z_reg, s_full[3:0]);
                fx_reg <= split_frac(x_reg, s_full[3:0]);
                fz_reg <= split_frac(z_reg, s_full[3:0]);
            end
            ST_TRD:
            begin
                case (step_reg)
                    3'd1:    h0_reg <= ram_rd_data;
                    3'd2:    h1_reg <= ram_rd_data;
                    3'd3:    h2_reg <= ram_rd_data;
                    default: h2_reg <= h2_reg;
                endcase
            end
            ST_BLEND:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        ma_reg <= MUL_W'(diff_x);
                        mb_reg <= MUL_W'(fx_reg[10:0]);
                    end
                    3'd1:
                    begin
                        ma_reg <= MUL_W'(diff_z);
                        mb_reg <= MUL_W'(fz_reg[10:0]);
                    end
                    3'd2:    wx_reg <= tab_kx + prod_reg[27:11];
                    default: wz_reg <= tab_kz + prod_reg[27:11];
                endcase
            end
            ST_HASH:
            begin
                // n*(n*n*h0 + h1) + h2, low 32 bits, one multiply at a time
                case (step_reg)
                    3'd0: n_reg <= hash_n;
                    3'd1:
                    begin
                        ma_reg <= $signed({1'b0, n_reg});
                        mb_reg <= $signed({1'b0, n_reg});
                    end
                    3'd3:
                    begin
                        ma_reg <= $signed({1'b0, prod_reg[31:0]});
                        mb_reg <= $signed({2'b0, h0_reg});
                    end
                    3'd5:
                    begin
                        ma_reg <= $signed({1'b0, prod_reg[31:0] + {1'b0, h1_reg}});
                        mb_reg <= $signed({1'b0, n_reg});
                    end
                    3'd7:    lat_reg[j_reg] <= lat_new;
                    default: n_reg <= n_reg;
                endcase
            end
            ST_SMOOTH:
            begin
                if ((cx_reg == 2'd0) && (cz_reg == 2'd0))
                begin
                    sm_reg <= sm_term;
                end
                else
                begin
                    sm_reg <= sm_reg + sm_term;
                end
                if ((cx_reg == 2'd2) && (cz_reg == 2'd2))
                begin
                    case (q_reg)
                        2'd0:    v0_reg <= sm_reg + sm_term;
                        2'd1:    v1_reg <= sm_reg + sm_term;
                        2'd2:    v2_reg <= sm_reg + sm_term;
                        default: v3_reg <= sm_reg + sm_term;
                    endcase
                end
            end
            ST_MIX:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        ma_reg  <= $signed({17'd0, mix_d[15:0]});
                        mb_reg  <= MUL_W'(mix_w);
                        mix_reg <= $signed({{4{mix_a[SM_W-1]}}, mix_a, 16'd0});
                    end
                    3'd1:
                    begin
                        ma_reg <= MUL_W'($signed(mix_d[SM_W:16]));
                        mb_reg <= MUL_W'(mix_w);
                    end
                    3'd2: mix_reg <= mix_reg + prod_reg[MIX_W-1:0];
                    3'd3: mix_reg <= mix_reg + $signed({prod_reg[39:0], 16'd0});
                    default:
                    begin
                        // floor to 34 fraction bits and write back
                        if (mi_reg == 2'd1)
                        begin
                            v2_reg <= mix_reg[51:16];
                        end
                        else
                        begin
                            v0_reg <= mix_reg[51:16];
                        end
                    end
                endcase
            end
            ST_WEIGHT:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        ma_reg <= MUL_W'(amp_reg);
                        mb_reg <= MUL_W'(p_reg);
                    end
                    3'd1:
                    begin
                        ma_reg <= MUL_W'(p_reg);
                        mb_reg <= MUL_W'(pers_reg);
                    end
                    3'd2: wt_reg <= prod_reg[32:8];
                    3'd3:
                    begin
                        p_reg  <= prod_reg[32:16];
                        ma_reg <= MUL_W'(oct_r);
                        mb_reg <= MUL_W'(wt_reg);
                    end
                    3'd5:
                    begin
                        acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
                        set_reg <= (SETR_W'(set_reg + 1'b1) == SETR_W'(TABLE_SETS))
                                   ? '0 : SETR_W'(set_reg + 1'b1);
                    end
                    default: wt_reg <= wt_reg;
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    // floor to Q16.16 and saturate
                    if ((acc_reg[63:61] == 3'b000) || (acc_reg[63:61] == 3'b111))
                    begin
                        out_data_reg <= acc_reg[61:30];
                    end
                    else
                    begin
                        out_data_reg <= acc_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                end
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
    end

endmodule

// ===== hdl/fvnh_ram.sv =====
module fvnh_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/fvnh_checker.sv =====
module fvnh_assert (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [31:0] m_tdata
);

    import fvnh_pkg::*;

    logic height_req, load_req;
    assign height_req = s_tvalid && s_tready && (s_tuser[0] == FUNC_HEIGHT);
    assign load_req   = s_tvalid && s_tready && (s_tuser[0] == FUNC_LOAD);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled height changed");

    a_busy_after_height: assert property (@(posedge clk) disable iff (!rst_n)
        height_req |=> !s_tready)
        else $error("ready right after a height request");

    a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_req |=> s_tready)
        else $error("load request stalled the input");

    a_no_instant_height: assert property (@(posedge clk) disable iff (!rst_n)
        height_req |=> !$rose(m_tvalid))
        else $error("height appeared one cycle after request");

endmodule

bind fractal_value_noise_height fvnh_assert u_fvnh_checker (.*);

// ===== bench/fvnh_checker.sv =====
module fvnh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    import fvnh_pkg::*;

    localparam int SETS    = 16;
    localparam int OCT_MAX = 8;

    // Raised-cosine weights, Q1.16, at k/32
    int blend_lut [0:32] = '{
        0, 158, 630, 1411, 2494, 3869, 5522, 7438,
        9598, 11980, 14563, 17321, 20228, 23256, 26375, 29556,
        32768, 35980, 39161, 42280, 45308, 48215, 50973, 53556,
        55938, 58098, 60014, 61667, 63042, 64125, 64906, 65378,
        65536
    };

    bit [30:0]   hash_words [0:SETS*3-1];
    logic [3:0]  octaves;
    logic [15:0] amplitude;
    logic [15:0] persist;
    logic [3:0]  first_set;
    logic [31:0] heights_due [$];

    function automatic longint lattice_val(input int gx, input int gz, input int set);
        bit [31:0] n;
        bit [31:0] t;
        int        b;
        longint    tl;
        b  = set * 3;
        n  = gx + gz * 42;
        n  = (n << 13) ^ n;
        t  = (n * (n * n * 32'(hash_words[b]) + 32'(hash_words[b + 1]))
              + 32'(hash_words[b + 2])) & 32'h7fff_ffff;
        tl = t;
        return 64'sd1073741824 - tl;
    endfunction

    function automatic longint smooth_val(input int gx, input int gz, input int set);
        longint corners;
        longint sides;
        corners = lattice_val(gx - 1, gz - 1, set) + lattice_val(gx + 1, gz - 1, set)
                + lattice_val(gx - 1, gz + 1, set) + lattice_val(gx + 1, gz + 1, set);
        sides   = lattice_val(gx, gz - 1, set) + lattice_val(gx + 1, gz, set)
                + lattice_val(gx - 1, gz, set) + lattice_val(gx, gz + 1, set);
        return 4 * lattice_val(gx, gz, set) + 2 * sides + corners;
    endfunction

    function automatic longint cos_weight(input int f16);
        int k;
        int r;
        k = (f16 >> 11) & 31;
        r = f16 & 2047;
        return blend_lut[k] + (((blend_lut[k + 1] - blend_lut[k]) * r) >> 11);
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint w);
        return (a * (65536 - w) + b * w) >>> 16;
    endfunction

    function automatic void split_coord(input int c, input int s,
                                        output int ip, output int f16);
        int mag;
        int q;
        int m;
        mag = (c < 0) ? -c : c;
        q   = mag >> s;
        m   = mag & ((1 << s) - 1);
        ip  = (c < 0) ? -q : q;
        f16 = (s != 0) ? (m << (16 - s)) : 0;
    endfunction

    function automatic logic [31:0] fbm_height(input int x, input int z);
        int     oct;
        int     s;
        int     set;
        int     xi, zi, fx, fz;
        longint wx, wz, r, acc, p, h;
        oct = octaves;
        if (oct == 0)
            oct = 1;
        if (oct > OCT_MAX)
            oct = OCT_MAX;
        acc = 0;
        p   = 65536;
        for (int i = 0; i < oct; i++)
        begin
            s   = oct - 1 - i;
            set = (first_set + i) % SETS;
            split_coord(x, s, xi, fx);
            split_coord(z, s, zi, fz);
            wx  = cos_weight(fx);
            wz  = cos_weight(fz);
            r   = lerp(lerp(smooth_val(xi, zi, set), smooth_val(xi + 1, zi, set), wx),
                       lerp(smooth_val(xi, zi + 1, set), smooth_val(xi + 1, zi + 1, set), wx),
                       wz) >>> 4;
            acc = acc + r * ((longint'(amplitude) * p) >> 8);
            p   = (p * longint'(persist)) >> 16;
        end
        h = acc >>> 30;
        if (h > 64'sd2147483647)
            h = 64'sd2147483647;
        if (h < -64'sd2147483648)
            h = -64'sd2147483648;
        return h[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves   = 4'd4;
            amplitude = 16'd2560;
            persist   = 16'd32768;
            first_set = 4'd0;
            errors    = 0;
            heights_due.delete();
            pending   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (heights_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: height with none due: expected none, actual %h",
                             $time, m_tdata);
                end
                else if (heights_due[0] !== m_tdata)
                begin
                    errors++;
                    $display("%0t: height mismatch: expected %h, actual %h",
                             $time, heights_due[0], m_tdata);
                    void'(heights_due.pop_front());
                end
                else
                    void'(heights_due.pop_front());
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == FUNC_LOAD)
                begin
                    if (s_tdata[37:32] < SETS * 3)
                        hash_words[s_tdata[37:32]] = s_tdata[68:38];
                end
                else
                    heights_due.push_back(fbm_height(int'($signed(s_tdata[15:0])),
                                                     int'($signed(s_tdata[31:16]))));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OCTAVES:   octaves   = cfg_data[3:0];
                    REG_AMPLITUDE: amplitude = cfg_data;
                    REG_PERSIST:   persist   = cfg_data;
                    REG_FIRST_SET: first_set = cfg_data[3:0];
                    default: ;
                endcase
            end
            pending = heights_due.size();
        end
    end

endmodule

// ===== bench/tb_fractal_value_noise_height.sv =====
module tb_fractal_value_noise_height;
    import fvnh_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // x_coord[15:0], z_coord[31:16], table_addr[37:32], table_word[68:38]
    logic [0:0]  s_tuser;   // func[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // height[31:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int errors;
    int pending;
    // calm: both sides run without idling; stall_left: receiver hold-off in cycles
    bit calm;
    int stall_left;

    fractal_value_noise_height u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fvnh_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit: well beyond the slowest legal run with every stall taken
    initial
    begin
        #(12 * 4000000);
        $display("tb_fractal_value_noise_height: errors");
        $finish;
    end

    // Receiver: idle now and then, or hold off for a counted stretch on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(99) < 6)
                m_tready = 1'b0;
            else
                m_tready = 1'b1;
        end
    end

    // Offer one request; hold it until accepted. Valid stays high into the next call.
    task automatic send_req(input logic fn, input logic [15:0] x, input logic [15:0] z,
                            input logic [5:0] addr, input logic [30:0] word);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {3'b000, word, addr, z, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait for every height, then let a trailing load finish
    task automatic drain();
        drop_valid();
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(4))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(80) - 40);
            2:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            3:       return 16'((1 << $urandom_range(15)) + $urandom_range(2) - 1);
            default: return 16'($urandom_range(600) - 300);
        endcase
    endfunction

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
                send_req(FUNC_LOAD, 16'($urandom), 16'($urandom),
                         6'($urandom_range(63)), 31'($urandom));
            else
                send_req(FUNC_HEIGHT, pick_coord(), pick_coord(),
                         6'($urandom), 31'($urandom));
        end
    endtask

    task automatic set_all(input int oct, input int amp, input int per, input int fs);
        write_reg(REG_OCTAVES, 16'(oct));
        write_reg(REG_AMPLITUDE, 16'(amp));
        write_reg(REG_PERSIST, 16'(per));
        write_reg(REG_FIRST_SET, 16'(fs));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = FUNC_HEIGHT;
        cfg_valid  = 1'b0;
        cfg_index  = REG_OCTAVES;
        cfg_data   = '0;
        calm       = 1'b0;
        stall_left = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole table before any height reads it, extremes of the word first
        for (int a = 0; a < 48; a++)
            send_req(FUNC_LOAD, 16'h0000, 16'hffff, 6'(a),
                     (a == 0) ? 31'h0 : (a == 1) ? 31'h7fff_ffff : 31'($urandom));
        // Address beyond the table: ignored
        send_req(FUNC_LOAD, 16'hffff, 16'h0000, 6'd63, 31'h7fff_ffff);

        // Directed heights at reset settings
        send_req(FUNC_HEIGHT, 16'h0000, 16'h0000, 6'd0, 31'd0);
        send_req(FUNC_HEIGHT, 16'h8000, 16'h8000, 6'd0, 31'd0);
        send_req(FUNC_HEIGHT, 16'h7fff, 16'h7fff, 6'h3f, 31'h7fff_ffff);
        send_req(FUNC_HEIGHT, 16'h7fff, 16'h8000, 6'd0, 31'd0);
        send_req(FUNC_HEIGHT, 16'h8000, 16'h7fff, 6'd0, 31'd0);
        send_req(FUNC_HEIGHT, 16'hffff, 16'h0001, 6'd0, 31'd0);
        send_req(FUNC_HEIGHT, 16'hfff9, 16'h0007, 6'd0, 31'd0);
        send_req(FUNC_HEIGHT, 16'h0005, 16'hfffb, 6'd0, 31'd0);
        drain();

        // One octave, full scale, last set: short items, so run the hold-off here
        set_all(1, 65535, 65535, 15);
        send_req(FUNC_HEIGHT, 16'h7fff, 16'h7fff, 6'd0, 31'd0);
        stall_left = 3000;
        random_items(20);
        drain();
        calm = 1'b1;
        random_items(40);
        calm = 1'b0;
        random_items(40);
        drain();

        // Octave count zero runs as one; zero amplitude
        set_all(0, 0, 32768, 3);
        random_items(30);
        drain();

        // Count above the limit saturates; persistence zero kills later octaves
        set_all(15, 256, 0, 7);
        random_items(25);
        drain();

        // Eight octaves at full scale, sets wrap from the last one
        set_all(8, 65535, 65535, 15);
        random_items(25);
        drain();

        set_all(2, $urandom_range(65535), $urandom_range(65535), $urandom_range(15));
        random_items(50);
        // Sender pauses until every height is back
        drop_valid();
        while (pending != 0)
            @(negedge clk);
        random_items(50);
        drain();

        set_all(3, $urandom_range(65535), $urandom_range(65535), $urandom_range(15));
        random_items(60);
        drain();

        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb_fractal_value_noise_height: clean");
        else
            $display("tb_fractal_value_noise_height: errors");
        $finish;
    end

endmodule
